// ===== design/vfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vfp_pkg
// Shared types and constants for the vision frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vfp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BODY  = 2'd1,
    OP_CLOSE = 2'd2
  } tok_op_e;

  typedef enum logic [2:0] {
    CC_DIGIT = 3'd0,
    CC_COMMA = 3'd1,
    CC_SPACE = 3'd2,
    CC_MINUS = 3'd3,
    CC_T     = 3'd4,
    CC_L     = 3'd5,
    CC_N     = 3'd6,
    CC_OTHER = 3'd7
  } char_cls_e;

  typedef enum logic [1:0] {
    FK_UNRECOG  = 2'd0,
    FK_TARGET   = 2'd1,
    FK_LINE     = 2'd2,
    FK_NOTARGET = 2'd3
  } frame_kind_e;

  typedef struct packed {
    tok_op_e   op;
    char_cls_e cls;
    logic [3:0] digit;
  } vfp_token_t;

endpackage

`default_nettype wire

// ===== design/vfp_rx_if.sv =====
// ----------------------------------------------------------------------------
// vfp_rx_if
// Byte input channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/vfp_res_if.sv =====
// ----------------------------------------------------------------------------
// vfp_res_if
// Result channel: one transaction per closed frame with the held vision data.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfp_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  frame_kind;
  logic               detected;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic        [31:0] target_area;
  logic        [7:0]  target_type;
  logic signed [15:0] line_start_x;
  logic signed [15:0] line_start_y;
  logic signed [15:0] line_end_x;
  logic signed [15:0] line_end_y;

  modport source (output valid, output frame_kind, output detected, output target_x,
                  output target_y, output target_area, output target_type,
                  output line_start_x, output line_start_y, output line_end_x,
                  output line_end_y, input ready);
  modport sink   (input valid, input frame_kind, input detected, input target_x,
                  input target_y, input target_area, input target_type,
                  input line_start_x, input line_start_y, input line_end_x,
                  input line_end_y, output ready);
endinterface

`default_nettype wire

// ===== design/vfp_front.sv =====
// ----------------------------------------------------------------------------
// vfp_front
// Frame tracking and byte classification; emits tokens into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_front
  import vfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  output logic            ready_o,
  input  wire logic       full_i,
  output logic            push_o,
  output vfp_token_t      token_o
);

  localparam int unsigned LEN_W = $clog2(FRAME_BYTES);

  logic             in_frame_q, in_frame_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             accept;
  char_cls_e        cls;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    if (byte_i >= CH_ZERO && byte_i <= CH_NINE) cls = CC_DIGIT;
    else if (byte_i == CH_COMMA)                cls = CC_COMMA;
    else if (byte_i == CH_SPACE)                cls = CC_SPACE;
    else if (byte_i == CH_MINUS)                cls = CC_MINUS;
    else if (byte_i == CH_T)                    cls = CC_T;
    else if (byte_i == CH_L)                    cls = CC_L;
    else if (byte_i == CH_N)                    cls = CC_N;
    else                                        cls = CC_OTHER;
  end

  always_comb begin
    in_frame_d    = in_frame_q;
    len_d         = len_q;
    push_o        = 1'b0;
    token_o.op    = OP_BODY;
    token_o.cls   = cls;
    token_o.digit = 4'(byte_i - CH_ZERO);
    if (accept && !byte_i[7]) begin
      if (byte_i == CH_DOLLAR) begin
        in_frame_d = 1'b1;
        len_d      = LEN_W'(1);
        push_o     = 1'b1;
        token_o.op = OP_START;
      end else if (in_frame_q) begin
        if (byte_i == CH_NL) begin
          in_frame_d = 1'b0;
          push_o     = 1'b1;
          token_o.op = OP_CLOSE;
        end else if (len_q < LEN_W'(FRAME_BYTES - 1)) begin
          len_d  = len_q + 1'b1;
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/vfp_queue.sv =====
// ----------------------------------------------------------------------------
// vfp_queue
// Small token FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_queue
  import vfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire vfp_token_t  token_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output vfp_token_t       head_o
);

  vfp_token_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= token_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/vfp_back.sv =====
// ----------------------------------------------------------------------------
// vfp_back
// Field parser, held vision data and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_back
  import vfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire vfp_token_t head_i,
  output logic            pop_o,
  vfp_res_if.source       res_o
);

  typedef enum logic [2:0] {
    HP_KIND  = 3'b001,
    HP_COMMA = 3'b010,
    HP_BODY  = 3'b100
  } hdr_phase_e;

  localparam logic [2:0] FIELD_AREA  = 3'd2;
  localparam logic [2:0] FIELD_LAST  = 3'd3;
  localparam logic [2:0] FIELD_COUNT = 3'd4;

  hdr_phase_e  hp_q, hp_d;
  frame_kind_e kind_q, kind_d, close_kind;
  logic [2:0]  fn_q, fn_d;
  logic [31:0] acc_q, acc_d;
  logic        minus_q, minus_d, dseen_q, dseen_d, halt_q, halt_d;
  logic [31:0] cap_q [4];
  logic [31:0] cap_d [4];
  logic        det_q, det_d;
  logic [15:0] hx_q, hx_d, hy_q, hy_d;
  logic [31:0] harea_q, harea_d;
  logic [7:0]  htype_q, htype_d;
  logic [15:0] line_q [4];
  logic [15:0] line_d [4];

  logic        fire, out_valid_q, slot_free, is_signed;
  logic [35:0] prod;
  logic [31:0] acc_inc, fin_val;
  logic [1:0]  kind_out_q;

  assign slot_free = !out_valid_q || res_o.ready;
  assign pop_o     = !empty_i && (head_i.op != OP_CLOSE || slot_free);
  assign is_signed = kind_q == FK_LINE || fn_q < FIELD_AREA;

  // acc*10 + digit, saturating at 2^32-1
  assign prod    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, head_i.digit};
  assign acc_inc = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

  always_comb begin
    if (is_signed) begin
      if (minus_q) begin
        fin_val = {16'd0, 16'd0 - ((acc_q > 32'd32768) ? 16'h8000 : acc_q[15:0])};
      end else begin
        fin_val = (acc_q > 32'd32767) ? 32'd32767 : acc_q;
      end
    end else if (fn_q == FIELD_AREA) begin
      fin_val = acc_q;
    end else begin
      fin_val = (acc_q > 32'd255) ? 32'd255 : acc_q;
    end
  end

  always_comb begin
    hp_d       = hp_q;
    kind_d     = kind_q;
    fn_d       = fn_q;
    acc_d      = acc_q;
    minus_d    = minus_q;
    dseen_d    = dseen_q;
    halt_d     = halt_q;
    cap_d      = cap_q;
    det_d      = det_q;
    hx_d       = hx_q;
    hy_d       = hy_q;
    harea_d    = harea_q;
    htype_d    = htype_q;
    line_d     = line_q;
    fire       = 1'b0;
    close_kind = (hp_q == HP_BODY) ? kind_q : FK_UNRECOG;
    if (pop_o) begin
      case (head_i.op)
        OP_START: begin
          hp_d    = HP_KIND;
          kind_d  = FK_UNRECOG;
          fn_d    = '0;
          acc_d   = '0;
          minus_d = 1'b0;
          dseen_d = 1'b0;
          halt_d  = 1'b0;
        end
        OP_BODY: begin
          if (!halt_q) begin
            case (hp_q)
              HP_KIND: begin
                case (head_i.cls)
                  CC_T: begin
                    kind_d = FK_TARGET;
                    hp_d   = HP_COMMA;
                  end
                  CC_L: begin
                    kind_d = FK_LINE;
                    hp_d   = HP_COMMA;
                  end
                  CC_N: begin
                    kind_d = FK_NOTARGET;
                    hp_d   = HP_BODY;
                    halt_d = 1'b1;
                  end
                  default: begin
                    kind_d = FK_UNRECOG;
                    halt_d = 1'b1;
                  end
                endcase
              end
              HP_COMMA: begin
                if (head_i.cls == CC_COMMA) begin
                  hp_d = HP_BODY;
                end else begin
                  kind_d = FK_UNRECOG;
                  halt_d = 1'b1;
                end
              end
              HP_BODY: begin
                if (head_i.cls == CC_DIGIT) begin
                  acc_d   = acc_inc;
                  dseen_d = 1'b1;
                end else if (dseen_q) begin
                  cap_d[fn_q[1:0]] = fin_val;
                  fn_d    = fn_q + 1'b1;
                  acc_d   = '0;
                  minus_d = 1'b0;
                  dseen_d = 1'b0;
                  if (head_i.cls != CC_COMMA || fn_q >= FIELD_LAST) halt_d = 1'b1;
                end else if (head_i.cls == CC_SPACE && !minus_q) begin
                  halt_d = halt_q;
                end else if (head_i.cls == CC_MINUS && !minus_q && is_signed) begin
                  minus_d = 1'b1;
                end else begin
                  halt_d = 1'b1;
                end
              end
              default: halt_d = 1'b1;
            endcase
          end
        end
        OP_CLOSE: begin
          fire = 1'b1;
          if (close_kind != FK_NOTARGET && !halt_q && dseen_q && fn_q < FIELD_COUNT) begin
            cap_d[fn_q[1:0]] = fin_val;
            fn_d    = fn_q + 1'b1;
            acc_d   = '0;
            minus_d = 1'b0;
            dseen_d = 1'b0;
          end
          case (close_kind)
            FK_TARGET: begin
              if (fn_d >= FIELD_COUNT) begin
                hx_d    = cap_d[0][15:0];
                hy_d    = cap_d[1][15:0];
                harea_d = cap_d[2];
                htype_d = cap_d[3][7:0];
                det_d   = 1'b1;
              end
            end
            FK_LINE: begin
              for (int i = 0; i < 4; i++) begin
                if (3'(i) < fn_d) line_d[i] = cap_d[i][15:0];
              end
              det_d   = 1'b1;
              htype_d = '0;
            end
            FK_NOTARGET: det_d = 1'b0;
            default:     det_d = det_q;
          endcase
        end
        default: fire = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
    if (fire) begin
      kind_out_q          <= close_kind;
      res_o.detected      <= det_d;
      res_o.target_x      <= hx_d;
      res_o.target_y      <= hy_d;
      res_o.target_area   <= harea_d;
      res_o.target_type   <= htype_d;
      res_o.line_start_x  <= line_d[0];
      res_o.line_start_y  <= line_d[1];
      res_o.line_end_x    <= line_d[2];
      res_o.line_end_y    <= line_d[3];
    end
  end

  assign res_o.frame_kind = kind_out_q;
  assign res_o.valid      = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= HP_KIND;
      kind_q      <= FK_UNRECOG;
      fn_q        <= '0;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      dseen_q     <= 1'b0;
      halt_q      <= 1'b0;
      det_q       <= 1'b0;
      hx_q        <= '0;
      hy_q        <= '0;
      harea_q     <= '0;
      htype_q     <= '0;
      line_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      hp_q    <= hp_d;
      kind_q  <= kind_d;
      fn_q    <= fn_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      dseen_q <= dseen_d;
      halt_q  <= halt_d;
      det_q   <= det_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      harea_q <= harea_d;
      htype_q <= htype_d;
      line_q  <= line_d;
      if (fire)             out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/vision_frame_parser.sv =====
// ----------------------------------------------------------------------------
// vision_frame_parser
// ASCII vision frame parser: byte stream in, one result per closing newline.
// Throughput: one byte per cycle; the back part stalls only while a result
//   waits unread in the output register, then the 4-entry token queue fills
//   and input ready drops until the result is taken and the queue drains.
// Path: with nothing queued ahead, the closing newline's token is written to
//   the token queue, then popped and the result loaded into the output register.
// Reset: asynchronous, clears frame state and all held vision data to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vision_frame_parser
  import vfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vfp_rx_if.sink    rx_i,
  vfp_res_if.source res_o
);

  logic       push, pop, full, empty;
  vfp_token_t tok_in, tok_head;

  vfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .byte_i  (rx_i.rx_byte),
    .ready_o (rx_i.ready),
    .full_i  (full),
    .push_o  (push),
    .token_o (tok_in)
  );

  vfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (tok_head)
  );

  vfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (tok_head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
